// ===== sv/rfct_pkg.sv =====
// ============================================================================
// rfct_pkg
// Shared types and constants for the range flip count tree.
// ============================================================================
`default_nettype none

package rfct_pkg;

    localparam int NUM_SWITCHES = 1024;
    localparam int IDX_W        = 11;
    localparam int CNT_W        = 11;
    localparam int SLOTS        = 2 * NUM_SWITCHES;
    localparam int ADDR_W       = $clog2(SLOTS);
    localparam int STK_DEPTH    = 32;
    localparam int STK_AW       = $clog2(STK_DEPTH);
    localparam int SP_W         = $clog2(STK_DEPTH + 1);

    localparam logic OP_TOGGLE = 1'b0;
    localparam logic OP_COUNT  = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_POP,
        ST_RD_NODE,
        ST_VISIT,
        ST_RD_KIDS,
        ST_WR_KIDS,
        ST_SUM_RD,
        ST_SUM_WR,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic              post;
        logic [ADDR_W-1:0] idx;
        logic [IDX_W-1:0]  lo;
        logic [IDX_W-1:0]  hi;
    } frame_t;

    typedef struct packed {
        logic             pend;
        logic [CNT_W:0]   ones;
    } node_t;

endpackage

`default_nettype wire

// ===== sv/rfct_ram.sv =====
// ============================================================================
// rfct_ram
// Generic single-port RAM with registered read data.
// ============================================================================
`default_nettype none

module rfct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ===== sv/range_flip_count_tree.sv =====
// ============================================================================
// range_flip_count_tree
// Segment tree of switches with lazy range flip and range count.
// ============================================================================
// Channel  Direction  Payload
// s_       in         op, range_low, range_high
// m_       out        on_count, range_error (count requests only)
// cfg_     in         active_count
// One request walks the tree with an explicit stack and one RAM port. A node
// inside the range is read and then flipped or added to the sum; a node that is
// split reads its children, pushes any pending flip down to them, and is visited
// again later, where a toggle rebuilds its sum. A bad range never leaves idle.
// Reset and every configuration write start a clearing pass over every node
// slot, one node per cycle, during which s_ready is low.
// A finished count waits in the output register until m_ready is high.
`default_nettype none

module range_flip_count_tree
    import rfct_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic             s_op,
    input  wire logic [IDX_W-1:0] s_range_low,
    input  wire logic [IDX_W-1:0] s_range_high,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic      [CNT_W-1:0] m_on_count,
    output logic                  m_range_error,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [IDX_W-1:0] cfg_data
);

    localparam int NW = $bits(node_t);

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic [IDX_W-1:0]    act_reg, act_next;
    logic                op_reg, op_next;
    logic [IDX_W-1:0]    a_reg, a_next, b_reg, b_next;
    logic [CNT_W-1:0]    sum_reg, sum_next;
    logic                mv_reg, mv_next;
    logic [CNT_W-1:0]    mc_reg, mc_next;
    logic                me_reg, me_next;
    frame_t              cur_reg, cur_next;
    node_t               node_reg, node_next;
    node_t               left_reg, left_next;
    logic [1:0]          ph_reg, ph_next;
    frame_t              stk [STK_DEPTH];
    logic [SP_W-1:0]     sp_reg, sp_next;
    logic [STK_AW-1:0]   sp_top, sp_wr0, sp_wr1;
    logic                push0, push1;
    frame_t              pf0, pf1;

    logic                we;
    logic [ADDR_W-1:0]   addr;
    node_t               wdata, rdata;

    logic [IDX_W-1:0]    mid;
    logic [ADDR_W-1:0]   lidx, ridx;
    logic [IDX_W:0]      lsz, rsz, csz;
    logic                covers, bad;

    rfct_ram #(.WIDTH(NW), .DEPTH(SLOTS)) u_ram (
        .aclk  (aclk),
        .we    (we),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    assign mid  = IDX_W'(({1'b0, cur_reg.lo} + {1'b0, cur_reg.hi}) >> 1);
    assign lsz  = {1'b0, mid} - {1'b0, cur_reg.lo} + 1'b1;
    assign rsz  = {1'b0, cur_reg.hi} - {1'b0, mid};
    assign csz  = {1'b0, cur_reg.hi} - {1'b0, cur_reg.lo} + 1'b1;
    assign lidx = cur_reg.idx + 1'b1;
    assign ridx = ADDR_W'(cur_reg.idx + (lsz << 1));
    assign covers = (cur_reg.lo >= a_reg) && (cur_reg.hi <= b_reg);
    assign bad = (s_range_low == '0) || (s_range_low > s_range_high)
               || (s_range_high > act_reg);

    assign sp_top = STK_AW'(sp_reg - 1'b1);
    assign sp_wr0 = STK_AW'(sp_reg);
    assign sp_wr1 = STK_AW'(sp_reg + 1'b1);

    assign s_ready   = (state_reg == ST_IDLE) && !mv_reg;
    assign cfg_ready = (state_reg == ST_IDLE) && !mv_reg;
    assign m_valid       = mv_reg;
    assign m_on_count    = mc_reg;
    assign m_range_error = me_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            act_reg   <= IDX_W'(NUM_SWITCHES);
            sp_reg    <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            act_reg   <= act_next;
            sp_reg    <= sp_next;
            mv_reg    <= mv_next;
        end
        op_reg   <= op_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        sum_reg  <= sum_next;
        mc_reg   <= mc_next;
        me_reg   <= me_next;
        cur_reg  <= cur_next;
        node_reg <= node_next;
        left_reg <= left_next;
        ph_reg   <= ph_next;
        if (push0) stk[sp_wr0] <= pf0;
        if (push1) stk[sp_wr1] <= pf1;
    end

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        act_next   = act_reg;
        op_next    = op_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        sum_next   = sum_reg;
        mv_next    = mv_reg;
        mc_next    = mc_reg;
        me_next    = me_reg;
        cur_next   = cur_reg;
        node_next  = node_reg;
        left_next  = left_reg;
        ph_next    = ph_reg;
        sp_next    = sp_reg;
        push0      = 1'b0;
        push1      = 1'b0;
        pf0        = cur_reg;
        pf1        = cur_reg;
        we         = 1'b0;
        addr       = cur_reg.idx;
        wdata      = '0;

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                we       = 1'b1;
                addr     = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(SLOTS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (cfg_valid && cfg_ready) begin
                    if (cfg_data == '0) begin
                        act_next = IDX_W'(1);
                    end else if (cfg_data > IDX_W'(NUM_SWITCHES)) begin
                        act_next = IDX_W'(NUM_SWITCHES);
                    end else begin
                        act_next = cfg_data;
                    end
                    clr_next   = '0;
                    state_next = ST_CLEAR;
                end else if (s_valid && s_ready) begin
                    op_next  = s_op;
                    a_next   = s_range_low;
                    b_next   = s_range_high;
                    sum_next = '0;
                    if (bad) begin
                        if (s_op == OP_COUNT) begin
                            mv_next = 1'b1;
                            mc_next = '0;
                            me_next = 1'b1;
                        end
                    end else begin
                        cur_next   = '{post: 1'b0, idx: '0, lo: IDX_W'(1), hi: act_reg};
                        state_next = ST_RD_NODE;
                    end
                end
            end
            ST_POP: begin
                if (sp_reg == '0) begin
                    state_next = (op_reg == OP_COUNT) ? ST_RESULT : ST_IDLE;
                end else begin
                    cur_next   = stk[sp_top];
                    sp_next    = sp_reg - 1'b1;
                    state_next = stk[sp_top].post ? ST_SUM_RD : ST_RD_NODE;
                    ph_next    = '0;
                end
            end
            ST_RD_NODE: begin
                state_next = ST_VISIT;
            end
            ST_VISIT: begin
                if (covers) begin
                    if (op_reg == OP_COUNT) begin
                        sum_next = sum_reg + CNT_W'(rdata.ones);
                    end else begin
                        we    = 1'b1;
                        wdata = '{pend: ~rdata.pend, ones: csz - rdata.ones};
                    end
                    state_next = ST_POP;
                end else begin
                    node_next  = rdata;
                    ph_next    = '0;
                    addr       = lidx;
                    state_next = ST_RD_KIDS;
                end
            end
            ST_RD_KIDS: begin
                ph_next = ph_reg + 1'b1;
                if (ph_reg == 2'd0) begin
                    addr      = ridx;
                    left_next = rdata;
                end else begin
                    addr       = ridx;
                    ph_next    = '0;
                    state_next = node_reg.pend ? ST_WR_KIDS : ST_SUM_WR;
                end
            end
            ST_WR_KIDS: begin
                ph_next = ph_reg + 1'b1;
                we      = 1'b1;
                if (ph_reg == 2'd0) begin
                    addr  = ridx;
                    wdata = '{pend: ~rdata.pend, ones: rsz - rdata.ones};
                end else if (ph_reg == 2'd1) begin
                    addr  = lidx;
                    wdata = '{pend: ~left_reg.pend, ones: lsz - left_reg.ones};
                end else begin
                    addr  = cur_reg.idx;
                    wdata = '{pend: 1'b0, ones: node_reg.ones};
                    ph_next    = '0;
                    state_next = ST_SUM_WR;
                end
            end
            ST_SUM_WR: begin
                // Push the post-order frame and, when both children are walked, the right child.
                push0 = 1'b1;
                pf0   = '{post: 1'b1, idx: cur_reg.idx, lo: cur_reg.lo, hi: cur_reg.hi};
                sp_next = sp_reg + 1'b1;
                if (b_reg > mid) begin
                    push1 = 1'b1;
                    pf1   = '{post: 1'b0, idx: ridx, lo: mid + 1'b1, hi: cur_reg.hi};
                    sp_next = sp_reg + 2'd2;
                end
                if (a_reg <= mid) begin
                    cur_next   = '{post: 1'b0, idx: lidx, lo: cur_reg.lo, hi: mid};
                    state_next = ST_RD_NODE;
                end else begin
                    cur_next   = '{post: 1'b0, idx: ridx, lo: mid + 1'b1, hi: cur_reg.hi};
                    sp_next    = sp_reg + 1'b1;
                    push1      = 1'b0;
                    state_next = ST_RD_NODE;
                end
            end
            ST_SUM_RD: begin
                ph_next = ph_reg + 1'b1;
                if (ph_reg == 2'd0) begin
                    addr = lidx;
                end else if (ph_reg == 2'd1) begin
                    addr      = ridx;
                    left_next = rdata;
                end else if (ph_reg == 2'd2) begin
                    addr = ridx;
                end else begin
                    if (op_reg == OP_TOGGLE) begin
                        we    = 1'b1;
                        addr  = cur_reg.idx;
                        wdata = '{pend: 1'b0, ones: left_reg.ones + rdata.ones};
                    end
                    ph_next    = '0;
                    state_next = ST_POP;
                end
            end
            ST_RESULT: begin
                mv_next    = 1'b1;
                mc_next    = sum_reg;
                me_next    = 1'b0;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("input taken while the tree walk is busy");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (sp_reg <= SP_W'(STK_DEPTH)))
        else $error("walk stack overflow");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && !m_ready) |=> (mv_reg && $stable(mc_reg)))
        else $error("pending result lost");

endmodule

`default_nettype wire

// ===== verif/range_flip_count_tree_tb.sv =====
// ============================================================================
// range_flip_count_tree_tb
// Self-checking bench for the range flip count tree. Requests go in through
// a queued driver and results are checked against a flat switch-row
// predictor. The run covers several active_count settings with random
// idling on the request channel and random back pressure on the result channel.
// ============================================================================
`default_nettype none

module range_flip_count_tree_tb;
    import rfct_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic             op;
        logic [IDX_W-1:0] lo;
        logic [IDX_W-1:0] hi;
    } request_t;

    typedef struct {
        logic [CNT_W-1:0] on_count;
        logic             range_error;
    } count_result_t;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic             s_op;
    logic [IDX_W-1:0] s_range_low;
    logic [IDX_W-1:0] s_range_high;
    logic             m_valid;
    logic             m_ready;
    logic [CNT_W-1:0] m_on_count;
    logic             m_range_error;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_data;

    request_t      pending_requests[$];
    count_result_t expected_counts[$];
    request_t      offered;
    bit            offer_busy;
    bit            switch_on[1:NUM_SWITCHES];
    int            switches_used;
    int            sender_idle_pct;
    int            receiver_idle_pct;
    int            hold_request;
    int            hold_left;
    int            fails;
    longint        cycle_count;

    range_flip_count_tree uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_range_low  (s_range_low),
        .s_range_high (s_range_high),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_on_count   (m_on_count),
        .m_range_error(m_range_error),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic clear_switches(input int used);
        for (int i = 1; i <= NUM_SWITCHES; i++) switch_on[i] = 1'b0;
        switches_used = used;
    endtask

    task automatic apply_request(input request_t req);
        count_result_t res;
        int            total;
        bit            bad;
        total = 0;
        bad = (req.lo == 0) || (req.lo > req.hi) || (req.hi > switches_used);
        if (req.op == OP_TOGGLE) begin
            if (!bad) begin
                for (int i = req.lo; i <= req.hi; i++) switch_on[i] = ~switch_on[i];
            end
        end else begin
            if (!bad) begin
                for (int i = req.lo; i <= req.hi; i++) total += switch_on[i];
            end
            res.on_count = bad ? '0 : total[CNT_W-1:0];
            res.range_error = bad;
            expected_counts.push_back(res);
        end
    endtask

    always @(negedge aclk) begin
        if (!offer_busy && pending_requests.size() != 0 &&
            $urandom_range(99) >= sender_idle_pct) begin
            offered = pending_requests.pop_front();
            offer_busy = 1'b1;
        end
        s_valid      <= offer_busy;
        s_op         <= offered.op;
        s_range_low  <= offered.lo;
        s_range_high <= offered.hi;
    end

    always @(negedge aclk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > 3_000_000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
        if (aresetn && s_valid && s_ready) begin
            apply_request(offered);
            offer_busy = 1'b0;
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_counts.size() == 0) begin
                $error("unexpected result: on_count %0d range_error %0d",
                       m_on_count, m_range_error);
                fails++;
            end else begin
                count_result_t want;
                want = expected_counts.pop_front();
                if (m_on_count !== want.on_count) begin
                    $error("on_count: expected %0d, actual %0d", want.on_count, m_on_count);
                    fails++;
                end
                if (m_range_error !== want.range_error) begin
                    $error("range_error: expected %0d, actual %0d",
                           want.range_error, m_range_error);
                    fails++;
                end
            end
        end
    end

    task automatic add_request(input logic op, input int lo, input int hi);
        request_t req;
        req.op = op;
        req.lo = lo[IDX_W-1:0];
        req.hi = hi[IDX_W-1:0];
        pending_requests.push_back(req);
    endtask

    task automatic wait_drained();
        while (pending_requests.size() != 0 || offer_busy || expected_counts.size() != 0)
            @(posedge aclk);
        repeat (3000) @(posedge aclk);
    endtask

    task automatic write_active_count(input int value);
        int used;
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value[IDX_W-1:0];
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        used = value[IDX_W-1:0];
        if (used < 1) used = 1;
        if (used > NUM_SWITCHES) used = NUM_SWITCHES;
        clear_switches(used);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic add_random_requests(input int num);
        int lo;
        int hi;
        for (int n = 0; n < num; n++) begin
            if ($urandom_range(9) == 0) begin
                add_request(1'($urandom_range(1)), $urandom_range(2047),
                            $urandom_range(2047));
            end else begin
                lo = $urandom_range(switches_used, 1);
                if ($urandom_range(2) == 0)
                    hi = $urandom_range(switches_used, lo);
                else
                    hi = (lo + $urandom_range(15) > switches_used) ?
                         switches_used : lo + $urandom_range(15);
                add_request(1'($urandom_range(1)), lo, hi);
            end
        end
    endtask

    initial begin
        int settings[6];
        settings = '{0, 2047, 1, 1024, 2, 700};
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_op = OP_TOGGLE;
        s_range_low = '0;
        s_range_high = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        offer_busy = 1'b0;
        offered = '{OP_TOGGLE, '0, '0};
        hold_request = 0;
        hold_left = 0;
        fails = 0;
        cycle_count = 0;
        sender_idle_pct = 26;
        receiver_idle_pct = 76;
        clear_switches(NUM_SWITCHES);
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        add_request(OP_COUNT, 1, 1024);
        add_request(OP_TOGGLE, 1, 1024);
        add_request(OP_COUNT, 1, 1024);
        add_request(OP_TOGGLE, 1, 1);
        add_request(OP_TOGGLE, 1024, 1024);
        add_request(OP_COUNT, 1, 1);
        add_request(OP_COUNT, 1024, 1024);
        add_request(OP_COUNT, 2, 1023);
        add_request(OP_TOGGLE, 512, 513);
        add_request(OP_COUNT, 500, 600);
        add_request(OP_COUNT, 0, 5);
        add_request(OP_TOGGLE, 0, 5);
        add_request(OP_COUNT, 9, 8);
        add_request(OP_TOGGLE, 9, 8);
        add_request(OP_COUNT, 1, 1025);
        add_request(OP_TOGGLE, 1, 1025);
        add_request(OP_COUNT, 2047, 2047);
        add_request(OP_COUNT, 1, 2047);
        add_request(OP_COUNT, 1, 1024);
        wait_drained();

        for (int p = 0; p < 6; p++) begin
            if (p == 2) begin
                sender_idle_pct = 76;
                receiver_idle_pct = 26;
            end else if (p == 4) begin
                sender_idle_pct = 0;
                receiver_idle_pct = 0;
            end
            write_active_count(settings[p]);
            if (p == 3) hold_request = 4000;
            add_random_requests(115);
            wait_drained();
        end

        if (fails == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
sv/rfct_pkg.sv
sv/rfct_ram.sv
sv/range_flip_count_tree.sv
verif/range_flip_count_tree_tb.sv
